// ===== sv/phso_pkg.sv =====
// ---------------------------------------------------------------------------
// phso_pkg
// Shared types, codes and constant tables of the harmonic sine oscillator.
// ---------------------------------------------------------------------------
package phso_pkg;

   localparam int STEP_BASE_BITS = 20;
   localparam int NOTE_BITS      = 7;
   localparam int VOICE_BITS     = 3;
   localparam int SAMPLE_BITS    = 16;
   localparam int GAIN_BITS      = 12;
   localparam int RATIO_BITS     = 17;
   localparam int HARM_IDX_BITS  = 3;
   localparam int ACC_BITS       = 40;
   localparam int PROD_BITS      = 29;
   localparam int STEP_PROD_BITS = STEP_BASE_BITS + RATIO_BITS;

   // step = (base * ratio) >> (STEP_SHIFT - octave)
   localparam int STEP_SHIFT  = 22;
   localparam int NOTE_OFFSET = 72;
   // octave = (n * RECIP_12) >> RECIP_SHIFT, exact for n below 136
   localparam int RECIP_12    = 171;
   localparam int RECIP_SHIFT = 11;
   localparam int SEMITONES   = 12;

   localparam logic [STEP_BASE_BITS-1:0]     STEP_BASE_RESET = 20'd153791;
   localparam logic signed [NOTE_BITS-1:0]   MIN_NOTE_RESET  = -7'sd57;
   localparam logic signed [NOTE_BITS-1:0]   NOTE_SILENT     = -7'sd64;

   // floor(acc / 2^15) leaves the sample range exactly when acc leaves +-2^30
   localparam logic signed [ACC_BITS-1:0] ACC_SAT_HI = 40'sh00_4000_0000;
   localparam logic signed [ACC_BITS-1:0] ACC_SAT_LO = -40'sh00_4000_0000;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = -16'sh8000;

   typedef enum logic {
      FUNC_RENDER = 1'b0,
      FUNC_WRITE  = 1'b1
   } func_type;

   typedef enum logic {
      CSR_STEP_BASE = 1'b0,
      CSR_MIN_NOTE  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic note_we;
      logic phase_we;
      logic rd_en;
      logic phase_clr;
   } mem_ctl_type;

   function automatic logic [GAIN_BITS-1:0] partial_gain(input logic [HARM_IDX_BITS-1:0] j);
      logic [GAIN_BITS-1:0] g;
      unique case (j)
         3'd0: g = 12'd3285;
         3'd1: g = 12'd1646;
         3'd2: g = 12'd825;
         3'd3: g = 12'd414;
         3'd4: g = 12'd207;
         3'd5: g = 12'd104;
         3'd6: g = 12'd52;
         3'd7: g = 12'd26;
      endcase
      return g;
   endfunction

   function automatic logic [RATIO_BITS-1:0] semi_ratio(input logic [3:0] s);
      logic [RATIO_BITS-1:0] r;
      unique case (s)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd69433;
         4'd2:    r = 17'd73562;
         4'd3:    r = 17'd77936;
         4'd4:    r = 17'd82570;
         4'd5:    r = 17'd87480;
         4'd6:    r = 17'd92682;
         4'd7:    r = 17'd98193;
         4'd8:    r = 17'd104032;
         4'd9:    r = 17'd110218;
         4'd10:   r = 17'd116772;
         4'd11:   r = 17'd123715;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/phso_ifs.sv =====
// ---------------------------------------------------------------------------
// phso_ifs
// Request and response channel interfaces, valid/ready handshake.
// ---------------------------------------------------------------------------
interface phso_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   func;
   logic [phso_pkg::VOICE_BITS-1:0]        voice;
   logic signed [phso_pkg::NOTE_BITS-1:0]  note;
   logic                                   wave_on;

   modport source (output valid, func, voice, note, wave_on, input ready);
   modport sink   (input valid, func, voice, note, wave_on, output ready);
endinterface

interface phso_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [phso_pkg::SAMPLE_BITS-1:0] sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

// ===== sv/phso_voice_mem.sv =====
// ---------------------------------------------------------------------------
// phso_voice_mem
// Note and phase memories, one write and one registered read port each,
// with per-voice valid bits standing in for the reset values.
// ---------------------------------------------------------------------------
module phso_voice_mem #(
   parameter int VOICES     = 8,
   parameter int PHASE_BITS = 24,
   parameter int VW         = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  phso_pkg::mem_ctl_type                  ctl,
   input  logic [VW-1:0]                          note_waddr,
   input  logic signed [phso_pkg::NOTE_BITS-1:0]  note_wdata,
   input  logic [VW-1:0]                          phase_waddr,
   input  logic [PHASE_BITS-1:0]                  phase_wdata,
   input  logic [VW-1:0]                          raddr,
   output logic signed [phso_pkg::NOTE_BITS-1:0]  note_q,
   output logic [PHASE_BITS-1:0]                  phase_q
);

   logic signed [phso_pkg::NOTE_BITS-1:0] note_mem [VOICES];
   logic [PHASE_BITS-1:0]                 phase_mem [VOICES];

   logic [VOICES-1:0]                     note_vld_ff,  note_vld_in;
   logic [VOICES-1:0]                     phase_vld_ff, phase_vld_in;
   logic signed [phso_pkg::NOTE_BITS-1:0] note_rd_ff;
   logic [PHASE_BITS-1:0]                 phase_rd_ff;
   logic                                  note_rv_ff;
   logic                                  phase_rv_ff;

   always_comb begin
      note_vld_in  = note_vld_ff;
      phase_vld_in = phase_vld_ff;
      if (ctl.note_we) begin
         note_vld_in[note_waddr] = 1'b1;
      end
      if (ctl.phase_clr) begin
         phase_vld_in = '0;
      end else if (ctl.phase_we) begin
         phase_vld_in[phase_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         note_vld_ff  <= '0;
         phase_vld_ff <= '0;
      end else begin
         note_vld_ff  <= note_vld_in;
         phase_vld_ff <= phase_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.note_we) begin
         note_mem[note_waddr] <= note_wdata;
      end
      if (ctl.phase_we) begin
         phase_mem[phase_waddr] <= phase_wdata;
      end
      if (ctl.rd_en) begin
         note_rd_ff  <= note_mem[raddr];
         phase_rd_ff <= phase_mem[raddr];
         note_rv_ff  <= note_vld_ff[raddr];
         phase_rv_ff <= phase_vld_ff[raddr];
      end
   end

   assign note_q  = note_rv_ff  ? note_rd_ff  : phso_pkg::NOTE_SILENT;
   assign phase_q = phase_rv_ff ? phase_rd_ff : '0;

endmodule

// ===== sv/phso_step.sv =====
// ---------------------------------------------------------------------------
// phso_step
// Phase increment from a note: octave and semitone split, ratio multiply,
// octave shift. Two register stages.
// ---------------------------------------------------------------------------
module phso_step #(
   parameter int PHASE_BITS = 24
) (
   input  logic                                   clock,
   input  logic [phso_pkg::STEP_BASE_BITS-1:0]    step_base,
   input  logic signed [phso_pkg::NOTE_BITS-1:0]  note,
   output logic [PHASE_BITS-1:0]                  step
);

   logic [7:0]                               n;
   logic [15:0]                              qm;
   logic [3:0]                               q;
   logic [7:0]                               q12;
   logic [3:0]                               s;
   logic [3:0]                               q1_ff, q2_ff;
   logic [phso_pkg::RATIO_BITS-1:0]          ratio1_ff;
   logic [phso_pkg::STEP_PROD_BITS-1:0]      prod_ff;
   logic [4:0]                               shamt;
   logic [phso_pkg::STEP_PROD_BITS-1:0]      shifted;

   always_comb begin
      n   = 8'(note) + 8'(phso_pkg::NOTE_OFFSET);
      qm  = 16'(n) * 16'(phso_pkg::RECIP_12);
      q   = 4'(qm >> phso_pkg::RECIP_SHIFT);
      q12 = 8'({q, 3'b000}) + 8'({q, 2'b00});
      s   = 4'(n - q12);
   end

   always_ff @(posedge clock) begin
      q1_ff     <= q;
      ratio1_ff <= phso_pkg::semi_ratio(s);
      q2_ff     <= q1_ff;
      prod_ff   <= phso_pkg::STEP_PROD_BITS'(step_base)
                   * phso_pkg::STEP_PROD_BITS'(ratio1_ff);
   end

   always_comb begin
      shamt   = 5'(phso_pkg::STEP_SHIFT) - {1'b0, q2_ff};
      shifted = prod_ff >> shamt;
      step    = PHASE_BITS'(shifted);
   end

endmodule

// ===== sv/phso_sine.sv =====
// ---------------------------------------------------------------------------
// phso_sine
// Quarter-wave sine table with registered read; quadrant folding on the
// address and sign applied on the way out.
// ---------------------------------------------------------------------------
module phso_sine #(
   parameter int PHASE_BITS     = 24,
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic                                    clock,
   input  logic [PHASE_BITS-1:0]                   phase,
   output logic signed [phso_pkg::SAMPLE_BITS-1:0] sine
);

   localparam int QN     = 2 ** (SINE_ADDR_BITS - 2);
   localparam int KW     = SINE_ADDR_BITS - 1;
   localparam int QSHIFT = 17 - SINE_ADDR_BITS;
   localparam int C0     = 51472;
   localparam int C1     = 21167;
   localparam int C2     = 2611;
   localparam int Q15    = 15;
   localparam int QMAX   = 32767;

   typedef logic [14:0] qtab_type [QN + 1];

   function automatic qtab_type build_qtab();
      qtab_type        tab;
      longint unsigned t, t2, p, s;
      for (int k = 0; k <= QN; k++) begin
         t  = 64'(k) << QSHIFT;
         t2 = (t * t) >> Q15;
         p  = 64'(C0) - ((t2 * (64'(C1) - ((t2 * 64'(C2)) >> Q15))) >> Q15);
         s  = (t * p) >> Q15;
         tab[k] = (s > 64'(QMAX)) ? 15'h7fff : 15'(s);
      end
      return tab;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   logic [SINE_ADDR_BITS-1:0] idx;
   logic [1:0]                quad;
   logic [KW-2:0]             f;
   logic [KW-1:0]             k_idx;
   logic [14:0]               rom_ff;
   logic                      neg_ff;

   always_comb begin
      idx   = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
      quad  = idx[SINE_ADDR_BITS-1 -: 2];
      f     = idx[SINE_ADDR_BITS-3:0];
      k_idx = quad[0] ? (KW'(QN) - {1'b0, f}) : {1'b0, f};
   end

   always_ff @(posedge clock) begin
      rom_ff <= QTAB[k_idx];
      neg_ff <= quad[1];
   end

   assign sine = neg_ff ? -$signed({1'b0, rom_ff}) : $signed({1'b0, rom_ff});

endmodule

// ===== sv/polyphonic_harmonic_sine_oscillator.sv =====
// ---------------------------------------------------------------------------
// polyphonic_harmonic_sine_oscillator
// Additive organ oscillator: per voice, HARMONICS weighted sine partials at
// octave multiples of the voice phase, summed over sounding voices.
//
//   channel  dir  payload                          handshake
//   req_if   in   func, voice, note, wave_on       valid/ready
//   rsp_if   out  sample (signed Q1.15)            valid/ready
//   csr_*    in   csr_index, csr_wdata             csr_we, no back-pressure
//
// A write word is done in the idle state. A render reads each voice in turn
// and runs each sounding one through the sine, gain, accumulate pipeline;
// a silent voice only passes its check state. A render while sound is off
// clears the phases and goes to finish. No clearing pass after reset.
// A stalled response holds its sample; writes are still taken and the next
// render runs, then waits in its finish state until the held sample leaves.
// ---------------------------------------------------------------------------
module polyphonic_harmonic_sine_oscillator #(
   parameter int VOICES         = 8,
   parameter int HARMONICS      = 4,
   parameter int PHASE_BITS     = 24,
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   phso_req_if.sink                             req_if,
   phso_rsp_if.source                           rsp_if,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [phso_pkg::STEP_BASE_BITS-1:0]  csr_wdata
);

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int HW = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_HARM   = 5'b00100,
      ST_WRITE  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type                                state_ff, state_in;
   logic [VW-1:0]                            voice_ff, voice_in;
   logic [HW-1:0]                            harm_ff, harm_in;
   logic signed [phso_pkg::ACC_BITS-1:0]     acc_ff, acc_in;
   logic                                     sound_en_ff, sound_en_in;
   logic [phso_pkg::STEP_BASE_BITS-1:0]      step_base_ff;
   logic signed [phso_pkg::NOTE_BITS-1:0]    min_note_ff;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic signed [phso_pkg::SAMPLE_BITS-1:0]  rsp_sample_ff, rsp_sample_in;

   logic                                     p1_vld_ff, p2_vld_ff, issue;
   logic [HW-1:0]                            p1_harm_ff;
   logic signed [phso_pkg::PROD_BITS-1:0]    prod_ff, prod_in;

   phso_pkg::mem_ctl_type                    mem_ctl;
   logic [VW-1:0]                            rd_addr;
   logic signed [phso_pkg::NOTE_BITS-1:0]    note_q;
   logic [PHASE_BITS-1:0]                    phase_q;
   logic [PHASE_BITS-1:0]                    step;
   logic [PHASE_BITS-1:0]                    harm_phase;
   logic [PHASE_BITS-1:0]                    phase_next;
   logic signed [phso_pkg::SAMPLE_BITS-1:0]  sine;
   logic [phso_pkg::GAIN_BITS-1:0]           gain;
   logic signed [phso_pkg::SAMPLE_BITS-1:0]  sat_sample;

   logic req_acc;
   logic last_voice;
   logic voice_ok;
   logic sounding;

   phso_voice_mem #(
      .VOICES     (VOICES),
      .PHASE_BITS (PHASE_BITS),
      .VW         (VW)
   ) u_mem (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mem_ctl),
      .note_waddr  (VW'(req_if.voice)),
      .note_wdata  (req_if.note),
      .phase_waddr (voice_ff),
      .phase_wdata (phase_next),
      .raddr       (rd_addr),
      .note_q      (note_q),
      .phase_q     (phase_q)
   );

   phso_step #(
      .PHASE_BITS (PHASE_BITS)
   ) u_step (
      .clock     (clock),
      .step_base (step_base_ff),
      .note      (note_q),
      .step      (step)
   );

   phso_sine #(
      .PHASE_BITS     (PHASE_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_sine (
      .clock (clock),
      .phase (harm_phase),
      .sine  (sine)
   );

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign req_acc       = req_if.valid && req_if.ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample = rsp_sample_ff;

   assign last_voice = (voice_ff == VW'(VOICES - 1));
   assign voice_ok   = (32'(req_if.voice) < 32'(VOICES));
   assign sounding   = (note_q >= min_note_ff);
   assign harm_phase = phase_q << harm_ff;
   assign phase_next = phase_q + step;

   // partial pipeline: table read, gain multiply, accumulate
   assign gain    = phso_pkg::partial_gain(phso_pkg::HARM_IDX_BITS'(p1_harm_ff));
   assign prod_in = phso_pkg::PROD_BITS'(sine)
                    * $signed(phso_pkg::PROD_BITS'({1'b0, gain}));

   always_comb begin
      if (acc_ff >= phso_pkg::ACC_SAT_HI) begin
         sat_sample = phso_pkg::SAMPLE_MAX;
      end else if (acc_ff < phso_pkg::ACC_SAT_LO) begin
         sat_sample = phso_pkg::SAMPLE_MIN;
      end else begin
         sat_sample = acc_ff[30:15];
      end
   end

   always_comb begin
      state_in      = state_ff;
      voice_in      = voice_ff;
      harm_in       = harm_ff;
      acc_in        = p2_vld_ff ? acc_ff + phso_pkg::ACC_BITS'(prod_ff) : acc_ff;
      sound_en_in   = sound_en_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_sample_in = rsp_sample_ff;
      mem_ctl       = '0;
      rd_addr       = VW'(voice_ff + 1'b1);
      issue         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_if.func == phso_pkg::FUNC_WRITE) begin
                  mem_ctl.note_we = voice_ok;
                  sound_en_in     = req_if.wave_on;
               end else if (sound_en_ff) begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = '0;
                  voice_in      = '0;
                  acc_in        = '0;
                  state_in      = ST_CHECK;
               end else begin
                  mem_ctl.phase_clr = 1'b1;
                  acc_in            = '0;
                  state_in          = ST_FINISH;
               end
            end
         end
         ST_CHECK: begin
            if (sounding) begin
               harm_in  = '0;
               state_in = ST_HARM;
            end else if (last_voice) begin
               state_in = ST_FINISH;
            end else begin
               voice_in      = VW'(voice_ff + 1'b1);
               mem_ctl.rd_en = 1'b1;
            end
         end
         ST_HARM: begin
            issue = 1'b1;
            if (harm_ff == HW'(HARMONICS - 1)) begin
               state_in = ST_WRITE;
            end else begin
               harm_in = HW'(harm_ff + 1'b1);
            end
         end
         ST_WRITE: begin
            mem_ctl.phase_we = 1'b1;
            if (last_voice) begin
               state_in = ST_FINISH;
            end else begin
               voice_in      = VW'(voice_ff + 1'b1);
               mem_ctl.rd_en = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!p1_vld_ff && !p2_vld_ff && (!rsp_valid_ff || rsp_if.ready)) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sat_sample;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sound_en_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         step_base_ff <= phso_pkg::STEP_BASE_RESET;
         min_note_ff  <= phso_pkg::MIN_NOTE_RESET;
      end else begin
         state_ff     <= state_in;
         sound_en_ff  <= sound_en_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_vld_ff    <= issue;
         p2_vld_ff    <= p1_vld_ff;
         if (csr_we) begin
            unique case (csr_index)
               phso_pkg::CSR_STEP_BASE: step_base_ff <= csr_wdata;
               phso_pkg::CSR_MIN_NOTE:  min_note_ff  <= $signed(csr_wdata[6:0]);
               default:                 step_base_ff <= step_base_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      voice_ff      <= voice_in;
      harm_ff       <= harm_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
      p1_harm_ff    <= harm_ff;
      prod_ff       <= prod_in;
   end

endmodule
